>>> rtl/tls_pkg.sv
// shared types, constants and command codes for the tape language stepper
package tls_pkg;

   localparam int TAPE_DEPTH_DEFAULT    = 32768;
   localparam int PROGRAM_DEPTH_DEFAULT = 4096;

   localparam int LEN_W    = 13;
   localparam int LDADDR_W = 12;
   localparam int BYTE_W   = 8;
   localparam int UNIT_W   = 17;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_PC_INC,
      ST_SCAN_MOV,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SET_PC,
      ST_FINISH
   } tls_state_type;

   typedef struct packed {
      logic [UNIT_W-1:0] operand;
      logic              dec;
   } tls_unit_req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] sum;
      logic              zero;
   } tls_unit_rsp_type;

endpackage

>>> rtl/tape_language_stepper.sv
// tape language stepper top level: sequencer, program store and tape
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser op, tdata load_address, byte_value
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata out_valid ... program_counter
//  csr     | in  | csr_valid/csr_ready    | csr_data program_length
//
//  a load or a step while halted goes from IDLE straight to FINISH; a plain command
//  passes DECODE and PC_INC; a bracket jump steps SCAN_MOV, SCAN_RD, SCAN_CHK per scanned byte, then SET_PC
//  the single shared incrementer and the registered memory reads set these step sequences
//  after reset the tape is cleared one cell a cycle, req not ready
//  a finished result waits in the output register; the next transfer is accepted meanwhile
module tape_language_stepper #(
   parameter int TAPE_DEPTH    = tls_pkg::TAPE_DEPTH_DEFAULT,
   parameter int PROGRAM_DEPTH = tls_pkg::PROGRAM_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // op
   input  logic [23:0] req_tdata,   // load_address[11:0], byte_value[19:12], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_valid[0], out_byte[8:1], input_used[9],
                                    // halted[10], bracket_error[11],
                                    // program_counter[24:12], zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data     // program_length
);

   localparam int DP_W    = $clog2(TAPE_DEPTH);
   localparam int PADDR_W = $clog2(PROGRAM_DEPTH);
   localparam int LEN_W   = tls_pkg::LEN_W;
   localparam int UNIT_W  = tls_pkg::UNIT_W;
   localparam int BYTE_W  = tls_pkg::BYTE_W;

   tls_pkg::tls_state_type state_ff, state_in;

   logic [LEN_W-1:0]   pc_ff, pc_in;
   logic [DP_W-1:0]    dp_ff, dp_in;
   logic               err_ff, err_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [DP_W-1:0]    clr_ff, clr_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [LEN_W-1:0]   depth_ff, depth_in;
   logic               dir_ff, dir_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               ovalid_ff, ovalid_in;
   logic [BYTE_W-1:0]  obyte_ff, obyte_in;
   logic               used_ff, used_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]        rsp_tdata_ff, rsp_tdata_in;

   logic [LEN_W-1:0]    eff_len;
   logic                halted;
   logic                req_xfer;
   logic                req_op;
   logic [tls_pkg::LDADDR_W-1:0] req_addr;
   logic [BYTE_W-1:0]   req_byte;

   logic                prog_we;
   logic [PADDR_W-1:0]  prog_waddr;
   logic [PADDR_W-1:0]  prog_raddr;
   logic [BYTE_W-1:0]   prog_rdata;

   logic                tape_we;
   logic [DP_W-1:0]     tape_waddr;
   logic [BYTE_W-1:0]   tape_wdata;
   logic [BYTE_W-1:0]   tape_rdata;

   logic                scan_up;
   logic                scan_down;

   tls_pkg::tls_unit_req_type unit_req;
   tls_pkg::tls_unit_rsp_type unit_rsp;

   assign req_op   = req_tuser;
   assign req_addr = req_tdata[11:0];
   assign req_byte = req_tdata[19:12];

   assign eff_len = (32'(len_ff) > PROGRAM_DEPTH) ? LEN_W'(PROGRAM_DEPTH) : len_ff;
   assign halted  = err_ff || (pc_ff >= eff_len);

   assign req_tready = (state_ff == tls_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign prog_we    = req_xfer && (req_op == tls_pkg::OP_LOAD) &&
                       (32'(req_addr) < PROGRAM_DEPTH);
   assign prog_waddr = PADDR_W'(req_addr);
   assign prog_raddr = (state_ff == tls_pkg::ST_SCAN_RD) ? PADDR_W'(idx_ff) : PADDR_W'(pc_ff);

   assign scan_up   = dir_ff ? (prog_rdata == tls_pkg::CMD_CLOSE) : (prog_rdata == tls_pkg::CMD_OPEN);
   assign scan_down = dir_ff ? (prog_rdata == tls_pkg::CMD_OPEN) : (prog_rdata == tls_pkg::CMD_CLOSE);

   tls_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(PROGRAM_DEPTH)
   ) u_program_store (
      .clock  (clock),
      .wr_en  (prog_we),
      .wr_addr(prog_waddr),
      .wr_data(req_byte),
      .rd_addr(prog_raddr),
      .rd_data(prog_rdata)
   );

   tls_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(TAPE_DEPTH)
   ) u_tape (
      .clock  (clock),
      .wr_en  (tape_we),
      .wr_addr(tape_waddr),
      .wr_data(tape_wdata),
      .rd_addr(dp_ff),
      .rd_data(tape_rdata)
   );

   tls_step_unit u_step_unit (
      .req(unit_req),
      .rsp(unit_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tls_pkg::ST_CLEAR;
         pc_ff         <= '0;
         dp_ff         <= '0;
         err_ff        <= 1'b0;
         len_ff        <= '0;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         dp_ff         <= dp_in;
         err_ff        <= err_in;
         len_ff        <= len_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      depth_ff     <= depth_in;
      dir_ff       <= dir_in;
      byte_ff      <= byte_in;
      ovalid_ff    <= ovalid_in;
      obyte_ff     <= obyte_in;
      used_ff      <= used_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_comb begin
      state_in      = state_ff;
      pc_in         = pc_ff;
      dp_in         = dp_ff;
      err_in        = err_ff;
      len_in        = csr_valid ? csr_data : len_ff;
      clr_in        = clr_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      dir_in        = dir_ff;
      byte_in       = byte_ff;
      ovalid_in     = ovalid_ff;
      obyte_in      = obyte_ff;
      used_in       = used_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      tape_we       = 1'b0;
      tape_waddr    = dp_ff;
      tape_wdata    = '0;
      unit_req.operand = UNIT_W'(pc_ff);
      unit_req.dec     = 1'b0;

      unique case (state_ff)
         tls_pkg::ST_CLEAR: begin
            tape_we          = 1'b1;
            tape_waddr       = clr_ff;
            unit_req.operand = UNIT_W'(clr_ff);
            clr_in           = unit_rsp.sum[DP_W-1:0];
            if (clr_ff == DP_W'(TAPE_DEPTH - 1)) begin
               state_in = tls_pkg::ST_IDLE;
            end
         end
         tls_pkg::ST_IDLE: begin
            if (req_xfer) begin
               byte_in   = req_byte;
               ovalid_in = 1'b0;
               obyte_in  = '0;
               used_in   = 1'b0;
               if (req_op == tls_pkg::OP_STEP && !halted) begin
                  state_in = tls_pkg::ST_DECODE;
               end else begin
                  state_in = tls_pkg::ST_FINISH;
               end
            end
         end
         tls_pkg::ST_DECODE: begin
            state_in = tls_pkg::ST_PC_INC;
            case (prog_rdata)
               tls_pkg::CMD_RIGHT: begin
                  unit_req.operand = UNIT_W'(dp_ff);
                  dp_in = (32'(unit_rsp.sum) >= TAPE_DEPTH) ? '0 : unit_rsp.sum[DP_W-1:0];
               end
               tls_pkg::CMD_LEFT: begin
                  unit_req.operand = UNIT_W'(dp_ff);
                  unit_req.dec     = 1'b1;
                  dp_in = (dp_ff == '0) ? DP_W'(TAPE_DEPTH - 1) : unit_rsp.sum[DP_W-1:0];
               end
               tls_pkg::CMD_INC, tls_pkg::CMD_DEC: begin
                  unit_req.operand = UNIT_W'(tape_rdata);
                  unit_req.dec     = (prog_rdata == tls_pkg::CMD_DEC);
                  tape_we          = 1'b1;
                  tape_wdata       = unit_rsp.sum[BYTE_W-1:0];
               end
               tls_pkg::CMD_OUT: begin
                  ovalid_in = 1'b1;
                  obyte_in  = tape_rdata;
               end
               tls_pkg::CMD_IN: begin
                  tape_we    = 1'b1;
                  tape_wdata = byte_ff;
                  used_in    = 1'b1;
               end
               tls_pkg::CMD_OPEN: begin
                  if (tape_rdata == '0) begin
                     idx_in   = pc_ff;
                     depth_in = LEN_W'(1);
                     dir_in   = 1'b0;
                     state_in = tls_pkg::ST_SCAN_MOV;
                  end
               end
               tls_pkg::CMD_CLOSE: begin
                  if (tape_rdata != '0) begin
                     idx_in   = pc_ff;
                     depth_in = LEN_W'(1);
                     dir_in   = 1'b1;
                     state_in = tls_pkg::ST_SCAN_MOV;
                  end
               end
               default: begin
               end
            endcase
         end
         tls_pkg::ST_PC_INC: begin
            pc_in    = unit_rsp.sum[LEN_W-1:0];
            state_in = tls_pkg::ST_FINISH;
         end
         tls_pkg::ST_SCAN_MOV: begin
            unit_req.operand = UNIT_W'(idx_ff);
            unit_req.dec     = dir_ff;
            if (dir_ff) begin
               if (idx_ff == '0) begin
                  err_in   = 1'b1;
                  state_in = tls_pkg::ST_FINISH;
               end else begin
                  idx_in   = unit_rsp.sum[LEN_W-1:0];
                  state_in = tls_pkg::ST_SCAN_RD;
               end
            end else begin
               if (unit_rsp.sum >= UNIT_W'(eff_len)) begin
                  err_in   = 1'b1;
                  state_in = tls_pkg::ST_FINISH;
               end else begin
                  idx_in   = unit_rsp.sum[LEN_W-1:0];
                  state_in = tls_pkg::ST_SCAN_RD;
               end
            end
         end
         tls_pkg::ST_SCAN_RD: begin
            state_in = tls_pkg::ST_SCAN_CHK;
         end
         tls_pkg::ST_SCAN_CHK: begin
            unit_req.operand = UNIT_W'(depth_ff);
            unit_req.dec     = scan_down;
            state_in         = tls_pkg::ST_SCAN_MOV;
            if (scan_up) begin
               depth_in = unit_rsp.sum[LEN_W-1:0];
            end else if (scan_down) begin
               depth_in = unit_rsp.sum[LEN_W-1:0];
               if (unit_rsp.zero) begin
                  state_in = tls_pkg::ST_SET_PC;
               end
            end
         end
         tls_pkg::ST_SET_PC: begin
            unit_req.operand = UNIT_W'(idx_ff);
            pc_in            = unit_rsp.sum[LEN_W-1:0];
            state_in         = tls_pkg::ST_FINISH;
         end
         tls_pkg::ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'b0, pc_ff, err_ff, halted, used_ff, obyte_ff, ovalid_ff};
               state_in      = tls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/tls_ram.sv
// generic single-write, single-read memory with registered read data
module tls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tls_step_unit.sv
// shared increment/decrement unit used by the steps of the sequencer that count up or down
module tls_step_unit (
   input  tls_pkg::tls_unit_req_type req,
   output tls_pkg::tls_unit_rsp_type rsp
);

   logic [tls_pkg::UNIT_W-1:0] sum;

   assign sum = req.operand + (req.dec ? {tls_pkg::UNIT_W{1'b1}} : tls_pkg::UNIT_W'(1));

   assign rsp.sum  = sum;
   assign rsp.zero = (sum == '0);

endmodule

>>> tb/sv/testbench.sv
// testbench for the tape language stepper: mirror of the machine, stream drivers and checks
`timescale 1ns / 100ps

typedef struct packed {
   logic [12:0] program_counter;
   logic        bracket_error;
   logic        halted;
   logic        input_used;
   logic [7:0]  out_byte;
   logic        out_valid;
} step_result_type;

class tape_mirror;
   localparam int TAPE_CELLS = tls_pkg::TAPE_DEPTH_DEFAULT;
   localparam int PROG_CELLS = tls_pkg::PROGRAM_DEPTH_DEFAULT;

   logic [7:0]   program_bytes [PROG_CELLS];
   logic [7:0]   cells [TAPE_CELLS];
   logic [12:0]  pc;
   logic [14:0]  dp;
   logic         error_seen;
   logic [12:0]  length_reg;
   step_result_type awaited [$];
   int           faults;

   function new();
      foreach (cells[k]) cells[k] = 8'h00;
      foreach (program_bytes[k]) program_bytes[k] = 8'h00;
      pc = '0;
      dp = '0;
      error_seen = 1'b0;
      length_reg = '0;
      faults = 0;
   endfunction

   function int unsigned eff_len();
      return (length_reg > PROG_CELLS) ? PROG_CELLS : length_reg;
   endfunction

   function bit halted_now();
      return error_seen || (pc >= eff_len());
   endfunction

   function void set_length(logic [12:0] value);
      length_reg = value;
   endfunction

   function bit seek_forward();
      int unsigned i;
      int unsigned depth;
      int unsigned len;
      len = eff_len();
      depth = 1;
      i = 32'(pc);
      while (1) begin
         i++;
         if (i >= len) return 1'b0;
         if (program_bytes[i] == tls_pkg::CMD_OPEN) depth++;
         else if (program_bytes[i] == tls_pkg::CMD_CLOSE) depth--;
         if (depth == 0) begin
            pc = 13'(i + 1);
            return 1'b1;
         end
      end
   endfunction

   function bit seek_backward();
      int unsigned i;
      int unsigned depth;
      depth = 1;
      i = 32'(pc);
      while (1) begin
         if (i == 0) return 1'b0;
         i--;
         if (program_bytes[i] == tls_pkg::CMD_CLOSE) depth++;
         else if (program_bytes[i] == tls_pkg::CMD_OPEN) depth--;
         if (depth == 0) begin
            pc = 13'(i + 1);
            return 1'b1;
         end
      end
   endfunction

   function void note_item(logic op, logic [11:0] addr, logic [7:0] val);
      step_result_type r;
      logic [7:0]   cmd;
      r = '0;
      if (op == tls_pkg::OP_LOAD) begin
         program_bytes[addr] = val;
      end else if (!halted_now()) begin
         cmd = program_bytes[pc];
         case (cmd)
            tls_pkg::CMD_RIGHT: begin
               dp = (dp == TAPE_CELLS - 1) ? '0 : dp + 1'b1;
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_LEFT: begin
               dp = (dp == 0) ? 15'(TAPE_CELLS - 1) : dp - 1'b1;
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_INC: begin
               cells[dp] = cells[dp] + 8'd1;
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_DEC: begin
               cells[dp] = cells[dp] - 8'd1;
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_OUT: begin
               r.out_valid = 1'b1;
               r.out_byte = cells[dp];
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_IN: begin
               cells[dp] = val;
               r.input_used = 1'b1;
               pc = pc + 1'b1;
            end
            tls_pkg::CMD_OPEN: begin
               if (cells[dp] == 8'h00) begin
                  if (!seek_forward()) error_seen = 1'b1;
               end else begin
                  pc = pc + 1'b1;
               end
            end
            tls_pkg::CMD_CLOSE: begin
               if (cells[dp] != 8'h00) begin
                  if (!seek_backward()) error_seen = 1'b1;
               end else begin
                  pc = pc + 1'b1;
               end
            end
            default: pc = pc + 1'b1;
         endcase
      end
      r.halted = halted_now();
      r.bracket_error = error_seen;
      r.program_counter = pc;
      awaited.push_back(r);
   endfunction

   function void field_check(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         faults++;
         if (faults <= 40)
            $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      end
   endfunction

   function void check_output(logic [31:0] word);
      step_result_type got;
      step_result_type want;
      got = step_result_type'(word[24:0]);
      if (awaited.size() == 0) begin
         faults++;
         if (faults <= 40)
            $display("%0t: result %h expected none actual transfer", $time, word);
         return;
      end
      want = awaited.pop_front();
      field_check("out_valid", want.out_valid, got.out_valid);
      field_check("out_byte", want.out_byte, got.out_byte);
      field_check("input_used", want.input_used, got.input_used);
      field_check("halted", want.halted, got.halted);
      field_check("bracket_error", want.bracket_error, got.bracket_error);
      field_check("program_counter", want.program_counter, got.program_counter);
   endfunction
endclass

module testbench;
   localparam int RANDOM_ITEMS = 900;
   localparam int STALL_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 3000;
   localparam int PROG_CELLS   = tls_pkg::PROGRAM_DEPTH_DEFAULT;

   typedef enum int {DRAIN_OPEN, DRAIN_HALF, DRAIN_SPARSE, DRAIN_PATTERN} drain_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;

   tape_mirror  mirror = new();
   int          items_sent = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   bit          offering = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned top = 0;
   logic [7:0]  segment_bytes [$];

   tape_language_stepper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) mirror.note_item(req_tuser, req_tdata[11:0], req_tdata[19:12]);
         if (rsp_tvalid && rsp_tready) mirror.check_output(rsp_tdata);
         if (csr_valid && csr_ready) mirror.set_length(csr_data);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver: changing stall patterns, one long hold-off on request
   initial begin
      drain_mode_type mode;
      int          mode_left;
      int          tick;
      mode = DRAIN_OPEN;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = drain_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               DRAIN_OPEN:   rsp_tready <= 1'b1;
               DRAIN_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               DRAIN_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   function automatic logic [7:0] quiet_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == tls_pkg::CMD_RIGHT || b == tls_pkg::CMD_LEFT || b == tls_pkg::CMD_INC ||
                 b == tls_pkg::CMD_DEC || b == tls_pkg::CMD_OUT || b == tls_pkg::CMD_IN ||
                 b == tls_pkg::CMD_OPEN || b == tls_pkg::CMD_CLOSE);
      return b;
   endfunction

   function automatic logic [7:0] plain_command();
      case ($urandom_range(0, 5))
         0:       return tls_pkg::CMD_RIGHT;
         1:       return tls_pkg::CMD_LEFT;
         2:       return tls_pkg::CMD_INC;
         3:       return tls_pkg::CMD_DEC;
         4:       return tls_pkg::CMD_OUT;
         default: return tls_pkg::CMD_IN;
      endcase
   endfunction

   // balanced bracket nesting with random commands and filler bytes
   function automatic void compose_segment();
      int n;
      int depth;
      segment_bytes.delete();
      n = $urandom_range(3, 20);
      depth = 0;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               if (depth < 4) begin
                  segment_bytes.push_back(tls_pkg::CMD_OPEN);
                  depth++;
                  if ($urandom_range(0, 1)) segment_bytes.push_back(tls_pkg::CMD_DEC);
               end
            end
            2: begin
               if (depth > 0) begin
                  segment_bytes.push_back(tls_pkg::CMD_CLOSE);
                  depth--;
               end
            end
            3:       segment_bytes.push_back(quiet_byte());
            default: segment_bytes.push_back(plain_command());
         endcase
      end
      while (depth > 0) begin
         segment_bytes.push_back(tls_pkg::CMD_CLOSE);
         depth--;
      end
   endfunction

   task automatic send_item(input logic op, input logic [11:0] addr, input logic [7:0] val);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0000, val, addr};
      offering = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 5) == 0) ? 20 : 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_step();
      send_item(tls_pkg::OP_STEP, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
   endtask

   task automatic stop_offer();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   task automatic write_length(input logic [12:0] value);
      stop_offer();
      do @(posedge clock); while (mirror.awaited.size() != 0);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_program(input int budget, output bit finished);
      int n;
      n = 0;
      while (!mirror.halted_now() && n < budget) begin
         send_step();
         n++;
      end
      finished = mirror.halted_now();
   endtask

   initial begin
      logic [7:0]  opening_prog [11];
      int unsigned seg_start;
      int unsigned tail;
      bit          finished;
      bit          held;
      bit          forward;
      held = 1'b0;
      opening_prog = '{tls_pkg::CMD_LEFT, tls_pkg::CMD_RIGHT, tls_pkg::CMD_DEC,
                       tls_pkg::CMD_OUT, tls_pkg::CMD_IN, tls_pkg::CMD_OPEN,
                       tls_pkg::CMD_DEC, tls_pkg::CMD_CLOSE, tls_pkg::CMD_OPEN,
                       tls_pkg::CMD_CLOSE, 8'h00};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty program, extreme load address and byte, then every command but increment
      write_length(13'd0);
      send_item(tls_pkg::OP_STEP, 12'hFFF, 8'hFF);
      send_item(tls_pkg::OP_LOAD, 12'hFFF, 8'hFF);
      foreach (opening_prog[k]) send_item(tls_pkg::OP_LOAD, 12'(k), opening_prog[k]);
      top = 11;
      write_length(13'(top));
      repeat (13) send_item(tls_pkg::OP_STEP, 12'h000, 8'h02);

      // random programs appended behind the program counter
      while (items_sent < RANDOM_ITEMS && top < 3500) begin
         seg_start = top;
         compose_segment();
         foreach (segment_bytes[k]) begin
            send_item(tls_pkg::OP_LOAD, 12'(top + k), segment_bytes[k]);
            if ($urandom_range(0, 7) == 0) send_step();
            if ($urandom_range(0, 9) == 0)
               send_item(tls_pkg::OP_LOAD,
                         12'($urandom_range(top + segment_bytes.size(), 4095)),
                         8'($urandom_range(0, 255)));
         end
         top += segment_bytes.size();
         if ($urandom_range(0, 3) == 0) begin
            write_length(13'($urandom_range(0, seg_start)));
            repeat ($urandom_range(1, 2)) send_step();
         end
         write_length(13'(top));
         run_program(60, finished);
         if (!finished) begin
            // endless loop: blank out the segment under the running program
            for (int unsigned a = seg_start; a < top; a++)
               send_item(tls_pkg::OP_LOAD, 12'(a), quiet_byte());
            run_program(PROG_CELLS, finished);
         end
         if (!held && items_sent >= 300) begin
            hold_request = 1'b1;
            held = 1'b1;
            repeat (24) send_step();
         end
         repeat ($urandom_range(0, 2)) send_step();
      end

      // one unmatched bracket: forward over a short tail, or backward over the whole program
      forward = 1'($urandom_range(0, 1));
      tail = $urandom_range(8, 48);
      send_item(tls_pkg::OP_LOAD, 12'(top), tls_pkg::CMD_IN);
      send_item(tls_pkg::OP_LOAD, 12'(top + 1), forward ? tls_pkg::CMD_OPEN : tls_pkg::CMD_CLOSE);
      for (int unsigned a = top + 2; a < top + 2 + tail; a++)
         send_item(tls_pkg::OP_LOAD, 12'(a),
                   ($urandom_range(0, 3) == 0) ? plain_command() : quiet_byte());
      write_length(forward ? 13'h1FFF : 13'd4096);
      send_item(tls_pkg::OP_LOAD, 12'hFFF, quiet_byte());
      write_length(forward ? 13'(top + 2 + tail) : 13'h1FFF);
      send_item(tls_pkg::OP_STEP, 12'($urandom_range(0, 4095)),
                forward ? 8'h00 : 8'($urandom_range(1, 255)));
      send_step();
      repeat (3) send_step();
      send_item(tls_pkg::OP_LOAD, 12'hFFF, 8'($urandom_range(0, 255)));
      send_step();

      stop_offer();
      do @(posedge clock); while (mirror.awaited.size() != 0);
      repeat (64) @(posedge clock);
      if (mirror.faults == 0 && mirror.awaited.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
